// ----- src/oaht_pkg.sv -----
`default_nettype none
package oaht_pkg;

   // Default sizes of the table and the key.
   localparam int CAPACITY_DEF  = 256;
   localparam int KEY_BYTES_DEF = 8;

   // Field widths fixed by the interface.
   localparam int ACTION_W = 2;
   localparam int KEY_W    = 64;
   localparam int VALUE_W  = 64;
   localparam int HASH_W   = 64;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 9;
   localparam int MODE_W   = 2;
   localparam int CSR_W    = 9;
   localparam int CSR_IDX_W = 1;

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // FNV-1a constants; the prime is 2^40 + 0x1b3.
   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
   localparam logic [8:0]        FNV_PRIME_LOW = 9'h1b3;
   localparam int                FNV_PRIME_SHIFT = 40;

   // Actions.
   localparam logic [ACTION_W-1:0] ACT_PUT    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_GET    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISSING = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

   // Probe modes.
   localparam logic [MODE_W-1:0] PROBE_LINEAR = 2'd0;
   localparam logic [MODE_W-1:0] PROBE_QUAD   = 2'd1;
   localparam logic [MODE_W-1:0] PROBE_DOUBLE = 2'd2;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_PROBE_MODE  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ENTRIES = 1'b1;
   localparam logic [MODE_W-1:0]    PROBE_MODE_RST  = PROBE_LINEAR;
   localparam logic [COUNT_W-1:0]   MAX_ENTRIES_RST = 9'd192;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  read_value;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      logic [VALUE_W-1:0]  value;
      logic [HASH_W-1:0]   hash;
   } job_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_type;

endpackage
`default_nettype wire

// ----- src/oaht_stream_if.sv -----
`default_nettype none
interface oaht_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- src/oaht_front.sv -----
`default_nettype none
module oaht_front #(
   parameter int CAPACITY  = oaht_pkg::CAPACITY_DEF,
   parameter int KEY_BYTES = oaht_pkg::KEY_BYTES_DEF
) (
   input var logic                         clock,
   input var logic                         reset,
   oaht_stream_if.sink                     req_if,
   output logic                            job_valid,
   input var logic                         job_ready,
   output oaht_pkg::job_type               job,
   output logic [$clog2(CAPACITY)-1:0]     job_hm,
   output logic [$clog2(CAPACITY)-1:0]     job_h2
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam logic [IDX_W:0] MOD_C = (IDX_W+1)'(CAPACITY);
   localparam logic [IDX_W:0] MOD_D = (IDX_W+1)'(CAPACITY - 1);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_HASH = 4'b0010,
      F_MOD  = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   front_state_type                    st_ff, st_in;
   oaht_pkg::req_type                  job_ff, job_in;
   logic [oaht_pkg::HASH_W-1:0]        hash_ff, hash_in;
   logic [3:0]                         byte_ff, byte_in;
   logic [IDX_W-1:0]                   rc_ff, rc_in;
   logic [IDX_W-1:0]                   rd_ff, rd_in;
   logic [oaht_pkg::KEY_W-1:0]         norm_key;
   logic                               keep;
   logic [7:0]                         cur_byte;
   logic [7:0]                         top_byte;

   // One FNV-1a round: xor the byte in, multiply by the prime as a shift and a small product.
   function automatic logic [oaht_pkg::HASH_W-1:0] fnv_step(
      input logic [oaht_pkg::HASH_W-1:0] h,
      input logic [7:0]                  b
   );
      logic [oaht_pkg::HASH_W-1:0] x;
      x = h ^ {56'd0, b};
      return (x << oaht_pkg::FNV_PRIME_SHIFT) + x * {55'd0, oaht_pkg::FNV_PRIME_LOW};
   endfunction

   // One byte of a remainder: shift the byte in and reduce by restoring subtraction.
   function automatic logic [IDX_W-1:0] mod_step(
      input logic [IDX_W-1:0] r,
      input logic [7:0]       b,
      input logic [IDX_W:0]   m
   );
      logic [IDX_W+7:0] x;
      logic [IDX_W+7:0] ms;
      x = {r, b};
      for (int i = 7; i >= 0; i--) begin
         ms = (IDX_W+8)'(m) << i;
         if (x >= ms) begin
            x = x - ms;
         end
      end
      return x[IDX_W-1:0];
   endfunction

   // Keep the key bytes below the first zero byte and within the key length.
   always_comb begin
      norm_key = '0;
      keep     = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (i >= KEY_BYTES || req_if.payload.key[8*i +: 8] == 8'd0) begin
            keep = 1'b0;
         end
         if (keep) begin
            norm_key[8*i +: 8] = req_if.payload.key[8*i +: 8];
         end
      end
   end

   // Hash one key byte per cycle, then reduce the hash one byte per cycle.
   always_comb begin
      st_in    = st_ff;
      job_in   = job_ff;
      hash_in  = hash_ff;
      byte_in  = byte_ff;
      rc_in    = rc_ff;
      rd_in    = rd_ff;
      cur_byte = job_ff.key[{byte_ff[2:0], 3'b000} +: 8];
      top_byte = hash_ff[{~byte_ff[2:0], 3'b000} +: 8];
      case (st_ff)
         F_IDLE: begin
            if (req_if.valid) begin
               job_in.action = req_if.payload.action;
               job_in.key    = norm_key;
               job_in.value  = req_if.payload.value;
               hash_in       = oaht_pkg::FNV_BASIS;
               byte_in       = '0;
               rc_in         = '0;
               rd_in         = '0;
               st_in         = F_HASH;
            end
         end
         F_HASH: begin
            if (byte_ff[3] || cur_byte == 8'd0) begin
               hash_in = (hash_ff == '0) ? 64'd1 : hash_ff;
               byte_in = '0;
               st_in   = F_MOD;
            end else begin
               hash_in = fnv_step(hash_ff, cur_byte);
               byte_in = byte_ff + 4'd1;
            end
         end
         F_MOD: begin
            rc_in   = mod_step(rc_ff, top_byte, MOD_C);
            rd_in   = mod_step(rd_ff, top_byte, MOD_D);
            byte_in = byte_ff + 4'd1;
            if (byte_ff[2:0] == 3'd7) begin
               st_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (job_ready) begin
               st_in = F_IDLE;
            end
         end
         default: begin
            st_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= F_IDLE;
      end else begin
         st_ff <= st_in;
      end
      job_ff  <= job_in;
      hash_ff <= hash_in;
      byte_ff <= byte_in;
      rc_ff   <= rc_in;
      rd_ff   <= rd_in;
   end

   assign req_if.ready = (st_ff == F_IDLE);
   assign job_valid    = (st_ff == F_PUSH);
   assign job.action   = job_ff.action;
   assign job.key      = job_ff.key;
   assign job.value    = job_ff.value;
   assign job.hash     = hash_ff;
   assign job_hm       = rc_ff;
   assign job_h2       = rd_ff + IDX_W'(1);

`ifndef SYNTHESIS
   a_hash_nonzero: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (hash_ff != '0))
      else $error("Hash handed to the back part is zero.");
`endif

endmodule
`default_nettype wire

// ----- src/oaht_queue.sv -----
`default_nettype none
module oaht_queue #(
   parameter int WIDTH = 8
) (
   input var logic             clock,
   input var logic             reset,
   input var logic             push_valid,
   output logic                push_ready,
   input var logic [WIDTH-1:0] push_data,
   output logic                pop_valid,
   input var logic             pop_ready,
   output logic [WIDTH-1:0]    pop_data
);

   localparam int DEPTH = oaht_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             push;
   logic             pop;

   // Pointers and fill level.
   always_comb begin
      push      = push_valid && push_ready;
      pop       = pop_valid && pop_ready;
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign push_ready = (count_ff != (PTR_W+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (PTR_W+1)'(DEPTH))
      else $error("Queue fill level beyond its depth.");
`endif

endmodule
`default_nettype wire

// ----- src/oaht_back.sv -----
`default_nettype none
module oaht_back #(
   parameter int CAPACITY = oaht_pkg::CAPACITY_DEF
) (
   input var logic                                clock,
   input var logic                                reset,
   input var logic                                job_valid,
   output logic                                   job_ready,
   input var oaht_pkg::job_type                   job,
   input var logic [$clog2(CAPACITY)-1:0]         job_hm,
   input var logic [$clog2(CAPACITY)-1:0]         job_h2,
   input var logic [oaht_pkg::MODE_W-1:0]         probe_mode,
   input var logic [oaht_pkg::COUNT_W-1:0]        max_entries,
   oaht_stream_if.source                          rsp_if
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int T_W   = 2 * IDX_W;
   localparam logic [IDX_W:0] CAP_S = (IDX_W+1)'(CAPACITY);
   // 2^64 mod CAPACITY, taken off when the 64-bit probe sum wraps.
   localparam longint unsigned P32      = (64'd1 << 32) % CAPACITY;
   localparam longint unsigned WRAP_ADJ = (P32 * P32) % CAPACITY;
   localparam logic [IDX_W:0]  WRAP_S   = (IDX_W+1)'(WRAP_ADJ);

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_READ = 4'b0010,
      B_EVAL = 4'b0100,
      B_DONE = 4'b1000
   } back_state_type;

   back_state_type                     st_ff, st_in;
   oaht_pkg::job_type                  cur_ff, cur_in;
   logic [IDX_W-1:0]                   hm_ff, hm_in;
   logic [IDX_W-1:0]                   h2_ff, h2_in;
   logic [IDX_W-1:0]                   att_ff, att_in;
   logic [T_W-1:0]                     t_ff, t_in;
   logic [IDX_W-1:0]                   tm_ff, tm_in;
   logic [IDX_W-1:0]                   dm_ff, dm_in;
   logic                               seen_ff, seen_in;
   logic [IDX_W-1:0]                   tomb_idx_ff, tomb_idx_in;
   logic [IDX_W-1:0]                   idx_ff;
   logic                               occ_rd_ff;
   logic                               tomb_rd_ff;
   oaht_pkg::slot_type                 row_ff;
   logic [CAPACITY-1:0]                occ_ff, occ_in;
   logic [CAPACITY-1:0]                tomb_ff, tomb_in;
   logic [oaht_pkg::COUNT_W-1:0]       count_ff, count_in;
   oaht_pkg::rsp_type                  res_ff, res_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   oaht_pkg::rsp_type                  rsp_data_ff, rsp_data_in;
   oaht_pkg::slot_type                 slot_mem [CAPACITY];
   logic                               mem_we;
   logic [IDX_W-1:0]                   mem_wa;
   oaht_pkg::slot_type                 mem_wd;
   logic [IDX_W:0]                     sum_a;
   logic [IDX_W:0]                     sum_b;
   logic [IDX_W:0]                     sum_c;
   logic [oaht_pkg::HASH_W:0]          wide_sum;
   logic [IDX_W-1:0]                   probe_idx;
   logic                               hit;
   logic                               empty;
   logic                               last;
   logic                               free_ok;
   logic [IDX_W-1:0]                   free_idx;

   function automatic logic [IDX_W-1:0] mod_add(
      input logic [IDX_W-1:0] a,
      input logic [IDX_W-1:0] b
   );
      logic [IDX_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= CAP_S) begin
         s = s - CAP_S;
      end
      return s[IDX_W-1:0];
   endfunction

   // Slot of the current attempt: residues add up modulo the capacity, and a wrap
   // of the 64-bit sum takes 2^64 mod capacity off again.
   always_comb begin
      sum_a    = {1'b0, hm_ff} + {1'b0, tm_ff};
      sum_b    = (sum_a >= CAP_S) ? sum_a - CAP_S : sum_a;
      wide_sum = {1'b0, cur_ff.hash} + {{(oaht_pkg::HASH_W+1-T_W){1'b0}}, t_ff};
      if (wide_sum[oaht_pkg::HASH_W]) begin
         sum_c = (sum_b >= WRAP_S) ? sum_b - WRAP_S : sum_b + CAP_S - WRAP_S;
      end else begin
         sum_c = sum_b;
      end
      probe_idx = sum_c[IDX_W-1:0];
   end

   // Classification of the slot just read.
   always_comb begin
      hit      = occ_rd_ff && (row_ff.key == cur_ff.key);
      empty    = !occ_rd_ff && !tomb_rd_ff;
      last     = (att_ff == IDX_W'(CAPACITY - 1));
      free_ok  = seen_ff || empty || tomb_rd_ff;
      free_idx = seen_ff ? tomb_idx_ff : idx_ff;
   end

   // Probe sequencer.
   always_comb begin
      st_in        = st_ff;
      cur_in       = cur_ff;
      hm_in        = hm_ff;
      h2_in        = h2_ff;
      att_in       = att_ff;
      t_in         = t_ff;
      tm_in        = tm_ff;
      dm_in        = dm_ff;
      seen_in      = seen_ff;
      tomb_idx_in  = tomb_idx_ff;
      occ_in       = occ_ff;
      tomb_in      = tomb_ff;
      count_in     = count_ff;
      res_in       = res_ff;
      mem_we       = 1'b0;
      mem_wa       = idx_ff;
      mem_wd.key   = cur_ff.key;
      mem_wd.value = cur_ff.value;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (st_ff)
         B_IDLE: begin
            if (job_valid) begin
               cur_in  = job;
               hm_in   = job_hm;
               h2_in   = job_h2;
               att_in  = '0;
               t_in    = '0;
               tm_in   = '0;
               dm_in   = IDX_W'(1);
               seen_in = 1'b0;
               if (job.action == oaht_pkg::ACT_PUT || job.action == oaht_pkg::ACT_GET ||
                   job.action == oaht_pkg::ACT_REMOVE) begin
                  st_in = B_READ;
               end else begin
                  res_in.status      = oaht_pkg::STAT_OK;
                  res_in.read_value  = '0;
                  res_in.entry_count = count_ff;
                  st_in              = B_DONE;
               end
            end
         end
         B_READ: begin
            st_in = B_EVAL;
         end
         B_EVAL: begin
            res_in.status     = oaht_pkg::STAT_OK;
            res_in.read_value = '0;
            if (hit) begin
               case (cur_ff.action)
                  oaht_pkg::ACT_PUT: begin
                     mem_we = 1'b1;
                  end
                  oaht_pkg::ACT_GET: begin
                     res_in.read_value = row_ff.value;
                  end
                  default: begin
                     occ_in[idx_ff]  = 1'b0;
                     tomb_in[idx_ff] = 1'b1;
                     if (count_ff != '0) begin
                        count_in = count_ff - oaht_pkg::COUNT_W'(1);
                     end
                  end
               endcase
               st_in = B_DONE;
            end else if (empty || last) begin
               // Key absent: a put takes the first tombstone, else the empty slot, or reports full.
               if (cur_ff.action == oaht_pkg::ACT_PUT) begin
                  if (count_ff >= max_entries || !free_ok) begin
                     res_in.status = oaht_pkg::STAT_FULL;
                  end else begin
                     mem_we            = 1'b1;
                     mem_wa            = free_idx;
                     occ_in[free_idx]  = 1'b1;
                     tomb_in[free_idx] = 1'b0;
                     count_in          = count_ff + oaht_pkg::COUNT_W'(1);
                  end
               end else begin
                  res_in.status = oaht_pkg::STAT_MISSING;
               end
               st_in = B_DONE;
            end else begin
               if (tomb_rd_ff && !seen_ff) begin
                  seen_in     = 1'b1;
                  tomb_idx_in = idx_ff;
               end
               att_in = att_ff + IDX_W'(1);
               case (probe_mode)
                  oaht_pkg::PROBE_QUAD: begin
                     t_in  = t_ff + T_W'({att_ff, 1'b1});
                     tm_in = mod_add(tm_ff, dm_ff);
                     dm_in = mod_add(dm_ff, IDX_W'(2));
                  end
                  oaht_pkg::PROBE_DOUBLE: begin
                     t_in  = t_ff + T_W'(h2_ff);
                     tm_in = mod_add(tm_ff, h2_ff);
                  end
                  default: begin
                     t_in  = t_ff + T_W'(1);
                     tm_in = mod_add(tm_ff, IDX_W'(1));
                  end
               endcase
               st_in = B_READ;
            end
            res_in.entry_count = count_in;
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               st_in        = B_IDLE;
            end
         end
         default: begin
            st_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= B_IDLE;
         occ_ff       <= '0;
         tomb_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         occ_ff       <= occ_in;
         tomb_ff      <= tomb_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff      <= cur_in;
      hm_ff       <= hm_in;
      h2_ff       <= h2_in;
      att_ff      <= att_in;
      t_ff        <= t_in;
      tm_ff       <= tm_in;
      dm_ff       <= dm_in;
      seen_ff     <= seen_in;
      tomb_idx_ff <= tomb_idx_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      idx_ff      <= probe_idx;
      occ_rd_ff   <= occ_ff[probe_idx];
      tomb_rd_ff  <= tomb_ff[probe_idx];
   end

   // Slot memory: key and value of each slot, one write and one registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      row_ff <= slot_mem[probe_idx];
   end

   assign job_ready      = (st_ff == B_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_matches_flags: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(occ_ff))
      else $error("Live count differs from the number of occupied slots.");
   a_count_moves_in_eval: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> $past(st_ff == B_EVAL))
      else $error("Live count changed outside slot evaluation.");
   a_done_drains: assert property (@(posedge clock) disable iff (reset)
      (st_ff == B_DONE && !rsp_valid_ff) |=> (st_ff == B_IDLE))
      else $error("Finished result held back although the output is free.");
`endif

endmodule
`default_nettype wire

// ----- src/open_addressing_hash_table.sv -----
`default_nettype none
// Channel   Direction  Handshake        Payload
// req_if    in         valid / ready    action, key, value
// rsp_if    out        valid / ready    status, read_value, entry_count
// csr_*     in         csr_we only      csr_index, csr_wdata
//
// The front hashes one key byte a cycle, then reduces the hash modulo the capacity
// and modulo the capacity less one, byte by byte, and queues the item.
// The back probes each slot in a read state and an evaluate state, as the single
// slot memory read port is registered; it starts in idle and hands results over in done.
// Reset clears all slot flags and the live count at once; no clearing pass.
// The output register lets the back finish an item while a result waits.
module open_addressing_hash_table #(
   parameter int CAPACITY  = oaht_pkg::CAPACITY_DEF,
   parameter int KEY_BYTES = oaht_pkg::KEY_BYTES_DEF
) (
   input var logic                              clock,
   input var logic                              reset,
   oaht_stream_if.sink                          req_if,
   oaht_stream_if.source                        rsp_if,
   input var logic                              csr_we,
   input var logic [oaht_pkg::CSR_IDX_W-1:0]    csr_index,
   input var logic [oaht_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int JOB_W = $bits(oaht_pkg::job_type) + 2 * IDX_W;

   logic [oaht_pkg::MODE_W-1:0]  probe_mode_ff;
   logic [oaht_pkg::COUNT_W-1:0] max_entries_ff;
   logic                         push_valid;
   logic                         push_ready;
   oaht_pkg::job_type            push_job;
   logic [IDX_W-1:0]             push_hm;
   logic [IDX_W-1:0]             push_h2;
   logic                         pop_valid;
   logic                         pop_ready;
   logic [JOB_W-1:0]             pop_data;
   oaht_pkg::job_type            pop_job;
   logic [IDX_W-1:0]             pop_hm;
   logic [IDX_W-1:0]             pop_h2;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         probe_mode_ff  <= oaht_pkg::PROBE_MODE_RST;
         max_entries_ff <= oaht_pkg::MAX_ENTRIES_RST;
      end else if (csr_we) begin
         case (csr_index)
            oaht_pkg::CSR_PROBE_MODE: begin
               probe_mode_ff <= csr_wdata[oaht_pkg::MODE_W-1:0];
            end
            oaht_pkg::CSR_MAX_ENTRIES: begin
               max_entries_ff <= csr_wdata[oaht_pkg::COUNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Front: key normalisation, hashing and residues.
   oaht_front #(
      .CAPACITY  (CAPACITY),
      .KEY_BYTES (KEY_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .job_valid (push_valid),
      .job_ready (push_ready),
      .job       (push_job),
      .job_hm    (push_hm),
      .job_h2    (push_h2)
   );

   // Queue between the two parts.
   oaht_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_job, push_hm, push_h2}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_job, pop_hm, pop_h2} = pop_data;

   // Back: probing and slot updates.
   oaht_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (pop_valid),
      .job_ready   (pop_ready),
      .job         (pop_job),
      .job_hm      (pop_hm),
      .job_h2      (pop_h2),
      .probe_mode  (probe_mode_ff),
      .max_entries (max_entries_ff),
      .rsp_if      (rsp_if)
   );

endmodule
`default_nettype wire
